>>> design/sha1md_pkg.sv
package sha1md_pkg;

  // One message step as it travels through the queue.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } item_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] BLOCK_END  = 6'd63;

endpackage

>>> design/sha1_message_digest.sv
// SHA-1 digest engine fed one message byte per input transfer.
// Input channel: in_data_byte with in_has_byte (byte present) and in_last
// (end of message). A transfer happens when in_valid is high and in_stall is low.
// A transfer with neither a byte nor the end mark is dropped at the front.
// The front register feeds a short queue; the back end packs bytes into
// 64-byte blocks, runs the 80 rounds one per cycle and appends the padding.
// The back end takes no new bytes while it runs the rounds and the chaining
// add of a full block, so the round unit sets the throughput.
// At the end mark the padding bytes are written (up to 72 bytes, with one or
// two more compressions), then the five digest words h0..h4 leave through
// the output register, out_digest_last set on h4. With no output stalls,
// h1..h4 follow h0 one per cycle.
// Output channel: a transfer happens when out_valid is high and out_stall is low.
// While the receiver stalls, the word on the output holds and the back end
// waits; the queue keeps taking input until it fills, then in_stall rises.
// Synchronous reset (rst_n low) empties the queue, restores the initial
// chaining values and clears the byte count; after the digest the back end
// restores those on its own, while the queue keeps what it holds.
module sha1_message_digest #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic        out_digest_last
);
  import sha1md_pkg::*;

  q_stat_t q_stat;
  item_t   push_item;
  item_t   pop_item;
  logic    q_push;
  logic    q_pop;

  // Front: input register that discards empty steps.
  sha1md_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_has_byte  (in_has_byte),
    .in_last      (in_last),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  // The queue lets input keep flowing while the back end compresses.
  sha1md_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  // Back end: block packing, padding, rounds and digest output.
  sha1md_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_item          (pop_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_digest_last (out_digest_last)
  );

endmodule

>>> design/sha1md_front.sv
module sha1md_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic                in_has_byte,
  input  logic                in_last,
  input  sha1md_pkg::q_stat_t q_stat,
  output logic                q_push,
  output sha1md_pkg::item_t   q_item
);
  import sha1md_pkg::*;

  logic  hold_r, hold_nxt;
  item_t item_r, item_nxt;
  logic  acc;

  assign in_stall = hold_r && q_stat.full;
  assign acc      = in_valid && !in_stall;
  assign q_push   = hold_r && !q_stat.full;
  assign q_item   = item_r;

  always_comb begin
    hold_nxt = hold_r && !q_push;
    item_nxt = item_r;
    if (acc) begin
      // A step that carries neither a byte nor the end mark changes nothing.
      hold_nxt = in_has_byte || in_last;
      item_nxt = '{data_byte: in_data_byte, has_byte: in_has_byte, last: in_last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

>>> design/sha1md_fifo.sv
module sha1md_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sha1md_pkg::item_t   push_item,
  input  logic                pop,
  output sha1md_pkg::item_t   pop_item,
  output sha1md_pkg::q_stat_t q_stat
);
  import sha1md_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  item_t         mem_r [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign q_stat.full  = (cnt_r == FULL_CNT);
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_item     = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

endmodule

>>> design/sha1md_back.sv
module sha1md_back (
  input  logic                clk,
  input  logic                rst_n,
  input  sha1md_pkg::q_stat_t q_stat,
  input  sha1md_pkg::item_t   q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         out_digest_word,
  output logic                out_digest_last
);
  import sha1md_pkg::*;

  typedef enum logic [6:0] {
    ST_FEED  = 7'b0000001,
    ST_ROUND = 7'b0000010,
    ST_ADD   = 7'b0000100,
    ST_MARK  = 7'b0001000,
    ST_ZERO  = 7'b0010000,
    ST_LEN   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t      state_r, state_nxt;
  state_t      ret_r, ret_nxt;
  state_t      after_st;
  logic [31:0] h_r [5];
  logic [31:0] h_nxt [5];
  logic [31:0] v_r [5];
  logic [31:0] v_nxt [5];
  logic [31:0] sched_r [16];
  logic [31:0] sched_nxt [16];
  logic [23:0] word_r, word_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] cnt_r, cnt_nxt;
  logic [6:0]  round_r, round_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [31:0] oword_r, oword_nxt;
  logic        olast_r, olast_nxt;
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [63:0] bit_len;
  logic [2:0]  lsel;
  logic [31:0] f_val, k_val, w_new, tmp;

  assign out_valid       = ovalid_r;
  assign out_digest_word = oword_r;
  assign out_digest_last = olast_r;

  assign bit_len = {cnt_r[60:0], 3'b000};
  assign lsel    = 3'd7 - pos_r[2:0];

  // Round function and constant by round group.
  always_comb begin
    if (round_r < 7'd20) begin
      f_val = (v_r[1] & v_r[2]) | (~v_r[1] & v_r[3]);
      k_val = K_R0;
    end else if (round_r < 7'd40) begin
      f_val = v_r[1] ^ v_r[2] ^ v_r[3];
      k_val = K_R1;
    end else if (round_r < 7'd60) begin
      f_val = (v_r[1] & v_r[2]) | (v_r[1] & v_r[3]) | (v_r[2] & v_r[3]);
      k_val = K_R2;
    end else begin
      f_val = v_r[1] ^ v_r[2] ^ v_r[3];
      k_val = K_R3;
    end
    w_new = sched_r[13] ^ sched_r[8] ^ sched_r[2] ^ sched_r[0];
    tmp   = {v_r[0][26:0], v_r[0][31:27]} + f_val + v_r[4] + k_val + sched_r[0];
  end

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    after_st   = state_r;
    h_nxt      = h_r;
    v_nxt      = v_r;
    sched_nxt  = sched_r;
    word_nxt   = word_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    round_nxt  = round_r;
    oidx_nxt   = oidx_r;
    ovalid_nxt = ovalid_r && out_stall;
    oword_nxt  = oword_r;
    olast_nxt  = olast_r;
    q_pop      = 1'b0;
    wr_en      = 1'b0;
    wr_byte    = '0;

    unique case (state_r)
      ST_FEED: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          if (q_item.has_byte) begin
            wr_en   = 1'b1;
            wr_byte = q_item.data_byte;
            cnt_nxt = cnt_r + 64'd1;
          end
          after_st  = q_item.last ? ST_MARK : ST_FEED;
          state_nxt = after_st;
        end
      end
      ST_MARK: begin
        wr_en    = 1'b1;
        wr_byte  = PAD_MARK;
        after_st = ST_ZERO;
      end
      ST_ZERO: begin
        if (pos_r == LEN_POS) begin
          state_nxt = ST_LEN;
        end else begin
          wr_en    = 1'b1;
          after_st = ST_ZERO;
        end
      end
      ST_LEN: begin
        wr_en    = 1'b1;
        wr_byte  = bit_len[{lsel, 3'b000} +: 8];
        after_st = (pos_r == BLOCK_END) ? ST_OUT : ST_LEN;
      end
      ST_ROUND: begin
        v_nxt[4] = v_r[3];
        v_nxt[3] = v_r[2];
        v_nxt[2] = {v_r[1][1:0], v_r[1][31:2]};
        v_nxt[1] = v_r[0];
        v_nxt[0] = tmp;
        for (int i = 0; i < 15; i++) begin
          sched_nxt[i] = sched_r[i+1];
        end
        sched_nxt[15] = {w_new[30:0], w_new[31]};
        if (round_r == LAST_ROUND) begin
          round_nxt = '0;
          state_nxt = ST_ADD;
        end else begin
          round_nxt = round_r + 7'd1;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 5; i++) begin
          h_nxt[i] = h_r[i] + v_r[i];
        end
        state_nxt = ret_r;
      end
      ST_OUT: begin
        if (!ovalid_r || !out_stall) begin
          ovalid_nxt = 1'b1;
          oword_nxt  = h_r[oidx_r];
          olast_nxt  = (oidx_r == 3'd4);
          if (oidx_r == 3'd4) begin
            oidx_nxt  = '0;
            h_nxt     = H_INIT;
            cnt_nxt   = '0;
            pos_nxt   = '0;
            state_nxt = ST_FEED;
          end else begin
            oidx_nxt = oidx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_FEED;
      end
    endcase

    // Byte placement: bytes shift into a word, full words shift into the schedule line.
    if (wr_en) begin
      word_nxt = {word_r[15:0], wr_byte};
      pos_nxt  = pos_r + 6'd1;
      if (pos_r[1:0] == 2'b11) begin
        for (int i = 0; i < 15; i++) begin
          sched_nxt[i] = sched_r[i+1];
        end
        sched_nxt[15] = {word_r, wr_byte};
      end
      if (pos_r == BLOCK_END) begin
        v_nxt     = h_r;
        round_nxt = '0;
        ret_nxt   = after_st;
        state_nxt = ST_ROUND;
      end else begin
        state_nxt = after_st;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_FEED;
      ret_r    <= ST_FEED;
      h_r      <= H_INIT;
      pos_r    <= '0;
      cnt_r    <= '0;
      round_r  <= '0;
      oidx_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      h_r      <= h_nxt;
      pos_r    <= pos_nxt;
      cnt_r    <= cnt_nxt;
      round_r  <= round_nxt;
      oidx_r   <= oidx_nxt;
      ovalid_r <= ovalid_nxt;
    end
    v_r     <= v_nxt;
    sched_r <= sched_nxt;
    word_r  <= word_nxt;
    oword_r <= oword_nxt;
    olast_r <= olast_nxt;
  end

endmodule

>>> design/sha1md_checker.sv
module sha1md_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_digest_word,
  input logic        out_digest_last
);

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_word)
      && $stable(out_digest_last))
    else $error("stalled digest word changed");

  // Digest words leave back to back until h4.
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_digest_last |=> out_valid)
    else $error("gap inside digest burst");

  // Nothing follows h4 right away: a new digest needs padding first.
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_digest_last |=> !out_valid)
    else $error("word right after digest end");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind sha1_message_digest sha1md_checker u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_digest_word (out_digest_word),
  .out_digest_last (out_digest_last)
);

>>> sim/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the byte-serial SHA-1 digest engine.
// A scoreboard object keeps its own SHA-1 state. It is fed every input
// transfer that the engine accepts, predicts the five digest words that each
// end-of-message transfer must produce, and compares them in order with what
// comes out of the result channel. The stimulus first walks through a few
// hand-picked messages: the empty message, single bytes at the value extremes,
// "abc", and dropped steps. After that it sends random messages whose lengths
// cluster around the padding boundaries. Both sides pause in random bursts
// until the last stretch of the run, which goes at full speed.
module testbench;
  import sha1md_pkg::*;

  // Scoreboard: a SHA-1 model of its own plus the queue of digest words that
  // are still owed by the engine.
  class digest_scoreboard;
    logic [31:0] chain_value [5];
    logic [31:0] block_words [16];
    logic [63:0] message_len;
    logic [31:0] expected_words [$];
    logic        expected_last [$];
    int unsigned errors;
    int unsigned words_checked;
    int unsigned digests_predicted;

    function new();
      chain_value = H_INIT;
      message_len = '0;
      errors = 0;
      words_checked = 0;
      digests_predicted = 0;
      foreach (block_words[i]) block_words[i] = '0;
    endfunction

    // 80 rounds over the current block, then the chaining add.
    function void run_rounds();
      logic [31:0] a, b, c, d, e, f, k, w, sum;
      logic [31:0] sched [16];
      sched = block_words;
      a = chain_value[0];
      b = chain_value[1];
      c = chain_value[2];
      d = chain_value[3];
      e = chain_value[4];
      for (int r = 0; r < 80; r++) begin
        if (r >= 16) begin
          w = sched[(r + 13) & 15] ^ sched[(r + 8) & 15] ^ sched[(r + 2) & 15]
            ^ sched[r & 15];
          sched[r & 15] = {w[30:0], w[31]};
        end
        w = sched[r & 15];
        if (r < 20) begin
          f = (b & c) | (~b & d);
          k = K_R0;
        end else if (r < 40) begin
          f = b ^ c ^ d;
          k = K_R1;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = K_R2;
        end else begin
          f = b ^ c ^ d;
          k = K_R3;
        end
        sum = {a[26:0], a[31:27]} + f + e + k + w;
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = sum;
      end
      chain_value[0] += a;
      chain_value[1] += b;
      chain_value[2] += c;
      chain_value[3] += d;
      chain_value[4] += e;
    endfunction

    // Packs one byte big-endian at block offset pos; a full block is hashed.
    function void pack_byte(int unsigned pos, logic [7:0] value);
      int unsigned idx;
      idx = (pos >> 2) & 15;
      if ((pos & 3) == 0) block_words[idx] = {value, 24'h0};
      else block_words[idx][8 * (3 - (pos & 3)) +: 8] = value;
      if ((pos & 63) == 63) run_rounds();
    endfunction

    // Called for every accepted input transfer.
    function void note_step(logic [7:0] data, logic has_byte, logic last);
      logic [63:0] bit_len;
      int unsigned pos;
      if (has_byte) begin
        pack_byte(32'(message_len[5:0]), data);
        message_len++;
      end
      if (!last) return;
      // Padding: the marker byte, zeros up to the length field, then the
      // 64-bit bit count. This spills into a second block when the tail of
      // the message leaves fewer than nine free bytes.
      bit_len = message_len << 3;
      pos = 32'(message_len[5:0]);
      pack_byte(pos, PAD_MARK);
      pos = (pos + 1) & 63;
      while (pos != LEN_POS) begin
        pack_byte(pos, 8'h00);
        pos = (pos + 1) & 63;
      end
      for (int i = 0; i < 8; i++) pack_byte(LEN_POS + i, bit_len[8 * (7 - i) +: 8]);
      for (int i = 0; i < 5; i++) begin
        expected_words.push_back(chain_value[i]);
        expected_last.push_back(i == 4);
      end
      digests_predicted++;
      chain_value = H_INIT;
      message_len = '0;
    endfunction

    // Called for every accepted result transfer.
    function void check_word(logic [31:0] word, logic last);
      logic [31:0] exp_word;
      logic        exp_last;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected digest word %h (last %b), nothing was pending",
                 $time, word, last);
        errors++;
        return;
      end
      exp_word = expected_words.pop_front();
      exp_last = expected_last.pop_front();
      words_checked++;
      if (word !== exp_word) begin
        $display("%0t: digest word mismatch: expected %h, actual %h",
                 $time, exp_word, word);
        errors++;
      end
      if (last !== exp_last) begin
        $display("%0t: digest_last mismatch: expected %b, actual %b",
                 $time, exp_last, last);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_words.size();
    endfunction
  endclass

  // Generous bound, far above the slowest legal run with every pause at its
  // longest.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Message steps (bytes and end marks, not dropped steps) before the run
  // stops adding messages, and the digests that it must see at the least.
  localparam int unsigned TARGET_STEPS = 200;
  localparam int unsigned MIN_DIGESTS  = 12;
  // The last part of the run goes without pauses on either side.
  localparam int unsigned CALM_AFTER   = 160;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_has_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic        out_digest_last;

  logic        calm;
  int unsigned cycle_count;
  int unsigned stall_hold;
  int unsigned message_steps;
  int unsigned byte_steps;
  int unsigned dropped_steps;
  int unsigned messages_sent;

  digest_scoreboard scoreboard = new();

  sha1_message_digest u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_has_byte     (in_has_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_digest_last (out_digest_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d digest words still pending",
               $time, cycle_count, scoreboard.outstanding());
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: out_stall alternates between free-running stretches (some of
  // them long) and stall bursts. stall_hold counts the cycles that the
  // present level still has to last.
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 1) begin
      stall_hold <= stall_hold - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_hold <= ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 30);
    end else if ($urandom_range(0, 1) == 0) begin
      out_stall <= 1'b1;
      stall_hold <= $urandom_range(1, 19);
    end else begin
      stall_hold <= $urandom_range(1, 30);
    end
  end

  // Every result transfer is checked against the oldest predicted word.
  // Sampling happens at the edge, before any of this edge's updates land.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      scoreboard.check_word(out_digest_word, out_digest_last);
  end

  // Drives one step and holds it until the engine takes it. The step is
  // reported to the scoreboard at the edge where the transfer happens.
  task automatic send_step(input logic [7:0] data, input logic has_byte,
                           input logic last);
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_has_byte <= has_byte;
    in_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scoreboard.note_step(data, has_byte, last);
    if (has_byte || last) message_steps++;
    else dropped_steps++;
    if (has_byte) byte_steps++;
    if (last) messages_sent++;
  endtask

  // Sender pause: with odds of one in rate, valid drops for a pause of random length.
  // A rate of zero means a stretch without pauses.
  task automatic maybe_pause(input int unsigned rate);
    if (!calm && rate != 0 && $urandom_range(1, rate) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // One complete message of random bytes. The end mark rides either on the
  // final byte or on a separate step without a byte (the only way to end an
  // empty message). Dropped steps with neither a byte nor an end mark are
  // scattered in now and then.
  task automatic send_message(input int unsigned len, input int unsigned rate);
    logic tail_on_byte;
    tail_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
    for (int unsigned i = 0; i < len; i++) begin
      maybe_pause(rate);
      if ($urandom_range(0, 11) == 0) begin
        send_step(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        maybe_pause(rate);
      end
      send_step(8'($urandom_range(0, 255)), 1'b1, tail_on_byte && i == len - 1);
    end
    if (!tail_on_byte) begin
      maybe_pause(rate);
      send_step(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  initial begin
    int unsigned len;
    int unsigned rate;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data_byte <= 8'h00;
    in_has_byte <= 1'b0;
    in_last <= 1'b0;
    out_stall <= 1'b0;
    calm <= 1'b0;
    cycle_count = 0;
    stall_hold = 0;
    message_steps = 0;
    byte_steps = 0;
    dropped_steps = 0;
    messages_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A step with no byte and no end mark must be dropped
    // without touching the state.
    send_step(8'h5A, 1'b0, 1'b0);
    // The empty message: an end mark with no byte before it.
    send_step(8'hFF, 1'b0, 1'b1);
    // A single zero byte with the end mark on the same step.
    send_step(8'h00, 1'b1, 1'b1);
    // A single all-ones byte, then an end mark whose data byte must be
    // ignored.
    send_step(8'hFF, 1'b1, 1'b0);
    maybe_pause(2);
    send_step(8'hAA, 1'b0, 1'b1);
    // "abc", with a dropped step in the middle.
    send_step(8'h61, 1'b1, 1'b0);
    send_step(8'h00, 1'b0, 1'b0);
    send_step(8'h62, 1'b1, 1'b0);
    send_step(8'h63, 1'b1, 1'b1);
    // After a digest the engine is back at its initial state, so a second
    // empty message must give the same digest as the first.
    maybe_pause(2);
    send_step(8'h00, 1'b0, 1'b1);
    // Bytes around the sign bit and both ends of the range.
    send_step(8'h80, 1'b1, 1'b0);
    send_step(8'h7F, 1'b1, 1'b0);
    send_step(8'h01, 1'b1, 1'b0);
    send_step(8'hFE, 1'b1, 1'b1);

    // Random part. Most messages are short; a fair share sits exactly at the
    // lengths where the padding just fits, just spills into a second block,
    // or follows a full block.
    while (message_steps < TARGET_STEPS || messages_sent < MIN_DIGESTS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: len = $urandom_range(0, 12);
        7, 8: begin
          case ($urandom_range(0, 7))
            0: len = 55;
            1: len = 56;
            2: len = 57;
            3: len = 63;
            4: len = 64;
            5: len = 65;
            6: len = 119;
            default: len = 120;
          endcase
        end
        default: len = $urandom_range(13, 70);
      endcase
      case ($urandom_range(0, 3))
        0: rate = 0;
        1: rate = 2;
        2: rate = 6;
        default: rate = 20;
      endcase
      if (message_steps >= CALM_AFTER) calm <= 1'b1;
      send_message(len, rate);
    end
    in_valid <= 1'b0;

    // Drain: every predicted word has to arrive, then a quiet tail catches
    // any word that the engine should not have sent.
    while (scoreboard.outstanding() != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("Run covered %0d messages: %0d bytes, %0d dropped steps, %0d cycles.",
             messages_sent, byte_steps, dropped_steps, cycle_count);
    $display("Compared %0d digest words of %0d digests, %0d mismatches.",
             scoreboard.words_checked, scoreboard.digests_predicted,
             scoreboard.errors);
    if (scoreboard.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sha1_message_digest.f
design/sha1md_pkg.sv
design/sha1md_front.sv
design/sha1md_fifo.sv
design/sha1md_back.sv
design/sha1_message_digest.sv
design/sha1md_checker.sv
sim/testbench.sv
